// ===== src/trfe_pkg.sv =====
// ----------------------------------------------------------------------------
// trfe_pkg
// Shared types and constants of the tracking report field encoder: pipeline
// stage control, quantization factors, reciprocal multipliers and the
// aircraft kind table.
// ----------------------------------------------------------------------------
package trfe_pkg;

	localparam int STAGES = 5;

	localparam int IN_DATA_W  = 152;
	localparam int OUT_DATA_W = 120;
	localparam int PADDR_W    = 3;

	typedef struct packed {
		logic [STAGES-1:0] load;
	} stage_ctl_t;

	// configuration register indexes (paddr[2])
	localparam logic REG_OWN_ADDRESS   = 1'b0;
	localparam logic REG_OFFSET_ENABLE = 1'b1;

	// coordinates
	localparam logic [16:0] LAT_SCALE  = 17'd93206;
	localparam logic [16:0] LON_SCALE  = 17'd46603;
	localparam logic [23:0] COORD_DIV  = 24'd10000000;
	localparam logic [22:0] COORD_HALF = 23'd5000000;
	localparam int          EST_SHIFT  = 32;
	localparam logic [25:0] LAT_RECIP  =
		26'(((64'd1 << EST_SHIFT) * 64'd93206) / 64'd10000000);
	localparam logic [25:0] LON_RECIP  =
		26'(((64'd1 << EST_SHIFT) * 64'd46603) / 64'd10000000);

	// altitude
	localparam logic [12:0] ALT_MAX      = 13'd8190;
	localparam logic [11:0] ALT_FINE_MAX = 12'd2047;

	// speed: half km/h = knots_q4 * 463 / 2000
	localparam logic [8:0]  SPD_MUL      = 9'd463;
	localparam logic [9:0]  SPD_HALF     = 10'd1000;
	localparam int          SPD_SHIFT    = 26;
	localparam logic [19:0] SPD_RECIP    = 20'(((64'd1 << SPD_SHIFT) + 64'd124) / 64'd125);
	localparam logic [9:0]  SPD_MAX      = 10'd635;
	localparam logic [9:0]  SPD_FINE_MAX = 10'd127;

	// climb: tenths of m/s = fpm * 127 / 2500
	localparam logic [6:0]  CLB_MUL   = 7'd127;
	localparam logic [10:0] CLB_HALF  = 11'd1250;
	localparam int          CLB_SHIFT = 30;
	localparam logic [20:0] CLB_RECIP = 21'(((64'd1 << CLB_SHIFT) + 64'd624) / 64'd625);
	localparam logic [8:0]  CLB_MAX   = 9'd315;

	// heading: floor(q6 / 90)
	localparam int          HDG_SHIFT = 22;
	localparam logic [15:0] HDG_RECIP = 16'(((64'd1 << HDG_SHIFT) + 64'd89) / 64'd90);
	localparam logic [7:0]  HDG_MAX   = 8'd255;

	// divide by five for narrow values
	localparam int          DIV5_SHIFT = 13;
	localparam logic [10:0] DIV5_RECIP = 11'(((64'd1 << DIV5_SHIFT) + 64'd4) / 64'd5);

	// offset and shared seven-bit field limits
	localparam logic [7:0] OFS_MAX   = 8'd254;
	localparam logic [6:0] SMALL_MAX = 7'd63;

	typedef enum logic [2:0] {
		TYPE_OTHER       = 3'd0,
		TYPE_PARAGLIDER  = 3'd1,
		TYPE_HANG_GLIDER = 3'd2,
		TYPE_BALLOON     = 3'd3,
		TYPE_GLIDER      = 3'd4,
		TYPE_POWERED     = 3'd5,
		TYPE_HELICOPTER  = 3'd6,
		TYPE_UAV         = 3'd7
	} craft_type_t;

	localparam int KIND_COUNT = 17;

	localparam craft_type_t KIND_MAP [KIND_COUNT] = '{
		TYPE_OTHER, TYPE_GLIDER, TYPE_POWERED, TYPE_HELICOPTER,
		TYPE_PARAGLIDER, TYPE_POWERED, TYPE_HANG_GLIDER, TYPE_PARAGLIDER,
		TYPE_POWERED, TYPE_POWERED, TYPE_OTHER, TYPE_BALLOON,
		TYPE_BALLOON, TYPE_UAV, TYPE_OTHER, TYPE_OTHER, TYPE_OTHER
	};

endpackage

// ===== src/trfe_flow.sv =====
// ----------------------------------------------------------------------------
// trfe_flow
// Valid bits and ready chain of the five-stage pipeline. A stage loads when
// it is empty or when the stage after it moves on.
// ----------------------------------------------------------------------------
module trfe_flow (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   out_ready,
	output logic                   in_ready,
	output logic                   out_valid,
	output trfe_pkg::stage_ctl_t   ctl
);

	logic [trfe_pkg::STAGES-1:0] valid_q;
	logic [trfe_pkg::STAGES:0]   ready;
	logic [trfe_pkg::STAGES-1:0] valid_in;

	always_comb begin
		ready[trfe_pkg::STAGES] = out_ready;
		for (int k = trfe_pkg::STAGES - 1; k >= 0; k--) begin
			ready[k] = !valid_q[k] || ready[k+1];
		end
	end

	assign valid_in  = {valid_q[trfe_pkg::STAGES-2:0], in_valid};
	assign ctl.load  = ready[trfe_pkg::STAGES-1:0];
	assign in_ready  = ready[0];
	assign out_valid = valid_q[trfe_pkg::STAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int k = 0; k < trfe_pkg::STAGES; k++) begin
				if (ready[k]) begin
					valid_q[k] <= valid_in[k];
				end
			end
		end
	end

endmodule

// ===== src/trfe_coord.sv =====
// ----------------------------------------------------------------------------
// trfe_coord
// Latitude and longitude lanes: magnitude, reciprocal estimate of the
// rounded quotient, remainder check with one-step correction, sign restore.
// ----------------------------------------------------------------------------
module trfe_coord (
	input  logic                 clk,
	input  trfe_pkg::stage_ctl_t ctl,
	input  logic signed [30:0]   latitude_e7,
	input  logic signed [31:0]   longitude_e7,
	output logic [23:0]          lat_code,
	output logic [23:0]          lon_code
);

	localparam int LANES  = 2;
	localparam int PROD_W = 58;
	localparam int NUM_W  = 48;
	localparam logic [PROD_W-1:0] EST_RND = PROD_W'(1) << (trfe_pkg::EST_SHIFT - 1);

	logic signed [31:0] coord [LANES];
	logic [16:0]        scale [LANES];
	logic [25:0]        recip [LANES];

	logic               neg_s1  [LANES];
	logic [31:0]        mag_s1  [LANES];
	logic               neg_s2  [LANES];
	logic [23:0]        est_s2  [LANES];
	logic [NUM_W-1:0]   num_s2  [LANES];
	logic               neg_s3  [LANES];
	logic [23:0]        est_s3  [LANES];
	logic [NUM_W-1:0]   num_s3  [LANES];
	logic [NUM_W-1:0]   prod_s3 [LANES];
	logic               neg_s4  [LANES];
	logic [23:0]        q_s4    [LANES];
	logic [23:0]        code_s5 [LANES];

	assign coord[0] = 32'(latitude_e7);
	assign coord[1] = longitude_e7;
	assign scale[0] = trfe_pkg::LAT_SCALE;
	assign scale[1] = trfe_pkg::LON_SCALE;
	assign recip[0] = trfe_pkg::LAT_RECIP;
	assign recip[1] = trfe_pkg::LON_RECIP;

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		always_ff @(posedge clk) begin
			if (ctl.load[0]) begin
				neg_s1[i] <= coord[i][31];
				mag_s1[i] <= coord[i][31] ? 32'(-coord[i]) : 32'(coord[i]);
			end
			if (ctl.load[1]) begin
				neg_s2[i] <= neg_s1[i];
				est_s2[i] <= 24'((PROD_W'(mag_s1[i]) * PROD_W'(recip[i]) + EST_RND)
					>> trfe_pkg::EST_SHIFT);
				num_s2[i] <= NUM_W'(mag_s1[i]) * NUM_W'(scale[i])
					+ NUM_W'(trfe_pkg::COORD_HALF);
			end
			if (ctl.load[2]) begin
				neg_s3[i]  <= neg_s2[i];
				est_s3[i]  <= est_s2[i];
				num_s3[i]  <= num_s2[i];
				prod_s3[i] <= NUM_W'(est_s2[i]) * NUM_W'(trfe_pkg::COORD_DIV);
			end
			if (ctl.load[3]) begin
				neg_s4[i] <= neg_s3[i];
				q_s4[i]   <= (num_s3[i] - prod_s3[i] >= NUM_W'(trfe_pkg::COORD_DIV))
					? est_s3[i] + 24'd1 : est_s3[i];
			end
			if (ctl.load[4]) begin
				code_s5[i] <= neg_s4[i] ? (~q_s4[i] + 24'd1) : q_s4[i];
			end
		end
	end

	assign lat_code = code_s5[0];
	assign lon_code = code_s5[1];

endmodule

// ===== src/trfe_motion.sv =====
// ----------------------------------------------------------------------------
// trfe_motion
// Altitude, speed, climb, heading, offset, type and online fields, quantized
// over five register stages.
// ----------------------------------------------------------------------------
module trfe_motion (
	input  logic                 clk,
	input  trfe_pkg::stage_ctl_t ctl,
	input  logic                 offset_enable,
	input  logic signed [15:0]   altitude_m,
	input  logic signed [15:0]   pressure_altitude_m,
	input  logic [13:0]          speed_knots_q4,
	input  logic signed [15:0]   climb_fpm,
	input  logic [14:0]          heading_deg_q6,
	input  logic [4:0]           craft_kind,
	input  logic                 track_off,
	input  logic                 stealth,
	output logic [11:0]          altitude_word,
	output logic [2:0]           type_code,
	output logic                 online_flag,
	output logic [7:0]           speed_word,
	output logic [7:0]           climb_word,
	output logic [7:0]           heading_code,
	output logic [7:0]           offset_word
);

	localparam logic signed [16:0] OFS_LIM = 17'(trfe_pkg::OFS_MAX);

	// stage 1 logic
	logic [12:0] alt_clamp;
	logic [11:0] alt_coarse;
	logic [11:0] alt_word;
	trfe_pkg::craft_type_t kind_type;

	// stage 2 logic
	logic       ofs_neg;
	logic [7:0] ofs_mag;

	// stage 3 logic
	logic [8:0] hdg_q;
	logic [6:0] ofs_code;
	logic [7:0] ofs_word;

	// stage 5 logic
	logic [6:0] spd_div;
	logic [6:0] clb_div;
	logic [6:0] clb_bits;

	logic [11:0]           alt_s1, alt_s2, alt_s3, alt_s4, alt_s5;
	trfe_pkg::craft_type_t type_s1, type_s2, type_s3, type_s4, type_s5;
	logic                  online_s1, online_s2, online_s3, online_s4, online_s5;
	logic [13:0]           spd_s1;
	logic                  clb_neg_s1, clb_neg_s2, clb_neg_s3, clb_neg_s4;
	logic [15:0]           clb_mag_s1;
	logic                  stealth_s1, stealth_s2, stealth_s3;
	logic [14:0]           hdg_s1;
	logic signed [16:0]    ofs_diff_s1;
	logic                  ofs_none_s1;
	logic [22:0]           spd_n_s2;
	logic [21:0]           clb_n_s2;
	logic [30:0]           hdg_p_s2;
	logic                  ofs_neg_s2;
	logic [7:0]            ofs_mag_s2;
	logic [11:0]           spd_q_s3;
	logic [10:0]           clb_q_s3;
	logic [7:0]            hdg_s3, hdg_s4, hdg_s5;
	logic [7:0]            ofs_s3, ofs_s4;
	logic [9:0]            spd_c_s4;
	logic [8:0]            clb_c_s4;
	logic [7:0]            spd_s5, clb_s5, ofs_s5;

	always_comb begin
		if (altitude_m[15]) begin
			alt_clamp = '0;
		end else if (altitude_m[14:0] > 15'(trfe_pkg::ALT_MAX)) begin
			alt_clamp = trfe_pkg::ALT_MAX;
		end else begin
			alt_clamp = 13'(altitude_m[14:0]);
		end
		alt_coarse = 12'((14'(alt_clamp) + 14'd2) >> 2);
		if (alt_coarse > trfe_pkg::ALT_FINE_MAX) begin
			alt_coarse = trfe_pkg::ALT_FINE_MAX;
		end
		if (alt_clamp > 13'(trfe_pkg::ALT_FINE_MAX)) begin
			alt_word = {1'b1, alt_coarse[10:0]};
		end else begin
			alt_word = 12'(alt_clamp);
		end
		if (craft_kind < 5'(trfe_pkg::KIND_COUNT)) begin
			kind_type = trfe_pkg::KIND_MAP[craft_kind];
		end else begin
			kind_type = trfe_pkg::TYPE_OTHER;
		end
	end

	always_comb begin
		if (ofs_none_s1) begin
			ofs_neg = 1'b0;
			ofs_mag = '0;
		end else if (ofs_diff_s1 > OFS_LIM) begin
			ofs_neg = 1'b0;
			ofs_mag = trfe_pkg::OFS_MAX;
		end else if (ofs_diff_s1 < -OFS_LIM) begin
			ofs_neg = 1'b1;
			ofs_mag = trfe_pkg::OFS_MAX;
		end else begin
			ofs_neg = ofs_diff_s1[16];
			ofs_mag = ofs_diff_s1[16] ? 8'(-ofs_diff_s1) : 8'(ofs_diff_s1);
		end
	end

	always_comb begin
		hdg_q = 9'(hdg_p_s2 >> trfe_pkg::HDG_SHIFT);
		ofs_code = 7'((9'(ofs_mag_s2) + 9'd2) >> 2);
		if (ofs_mag_s2 > 8'(trfe_pkg::SMALL_MAX)) begin
			if (ofs_neg_s2) begin
				ofs_word = {1'b1, ~ofs_code + 7'd1};
			end else if (ofs_code > trfe_pkg::SMALL_MAX) begin
				ofs_word = {1'b1, trfe_pkg::SMALL_MAX};
			end else begin
				ofs_word = {1'b1, ofs_code};
			end
		end else begin
			ofs_word = {1'b0, ofs_neg_s2 ? (~ofs_mag_s2[6:0] + 7'd1) : ofs_mag_s2[6:0]};
		end
	end

	always_comb begin
		spd_div = 7'((21'(spd_c_s4 + 10'd2) * 21'(trfe_pkg::DIV5_RECIP))
			>> trfe_pkg::DIV5_SHIFT);
		clb_div = 7'((21'(10'(clb_c_s4) + 10'd2) * 21'(trfe_pkg::DIV5_RECIP))
			>> trfe_pkg::DIV5_SHIFT);
		if (clb_c_s4 > 9'(trfe_pkg::SMALL_MAX)) begin
			clb_bits = clb_neg_s4 ? (~clb_div + 7'd1) : clb_div;
		end else begin
			clb_bits = clb_neg_s4 ? (~clb_c_s4[6:0] + 7'd1) : clb_c_s4[6:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[0]) begin
			alt_s1      <= alt_word;
			type_s1     <= kind_type;
			online_s1   <= ~track_off;
			spd_s1      <= speed_knots_q4;
			clb_neg_s1  <= climb_fpm[15];
			clb_mag_s1  <= climb_fpm[15] ? 16'(-climb_fpm) : 16'(climb_fpm);
			stealth_s1  <= stealth;
			hdg_s1      <= heading_deg_q6;
			ofs_diff_s1 <= 17'(pressure_altitude_m) - 17'(altitude_m);
			ofs_none_s1 <= pressure_altitude_m == '0;
		end
		if (ctl.load[1]) begin
			alt_s2     <= alt_s1;
			type_s2    <= type_s1;
			online_s2  <= online_s1;
			clb_neg_s2 <= clb_neg_s1;
			stealth_s2 <= stealth_s1;
			spd_n_s2   <= 23'(spd_s1) * 23'(trfe_pkg::SPD_MUL) + 23'(trfe_pkg::SPD_HALF);
			clb_n_s2   <= 22'(clb_mag_s1) * 22'(trfe_pkg::CLB_MUL) + 22'(trfe_pkg::CLB_HALF);
			hdg_p_s2   <= 31'(hdg_s1) * 31'(trfe_pkg::HDG_RECIP);
			ofs_neg_s2 <= ofs_neg;
			ofs_mag_s2 <= ofs_mag;
		end
		if (ctl.load[2]) begin
			alt_s3     <= alt_s2;
			type_s3    <= type_s2;
			online_s3  <= online_s2;
			clb_neg_s3 <= clb_neg_s2;
			stealth_s3 <= stealth_s2;
			spd_q_s3   <= 12'((39'(spd_n_s2 >> 4) * 39'(trfe_pkg::SPD_RECIP))
				>> trfe_pkg::SPD_SHIFT);
			clb_q_s3   <= 11'((41'(clb_n_s2 >> 2) * 41'(trfe_pkg::CLB_RECIP))
				>> trfe_pkg::CLB_SHIFT);
			hdg_s3     <= (hdg_q > 9'(trfe_pkg::HDG_MAX)) ? trfe_pkg::HDG_MAX : hdg_q[7:0];
			ofs_s3     <= ofs_word;
		end
		if (ctl.load[3]) begin
			alt_s4     <= alt_s3;
			type_s4    <= type_s3;
			online_s4  <= online_s3;
			hdg_s4     <= hdg_s3;
			ofs_s4     <= ofs_s3;
			clb_neg_s4 <= clb_neg_s3;
			spd_c_s4   <= (spd_q_s3 > 12'(trfe_pkg::SPD_MAX)) ? trfe_pkg::SPD_MAX
				: spd_q_s3[9:0];
			if (stealth_s3) begin
				clb_c_s4 <= '0;
			end else if (clb_q_s3 > 11'(trfe_pkg::CLB_MAX)) begin
				clb_c_s4 <= trfe_pkg::CLB_MAX;
			end else begin
				clb_c_s4 <= clb_q_s3[8:0];
			end
		end
		if (ctl.load[4]) begin
			alt_s5    <= alt_s4;
			type_s5   <= type_s4;
			online_s5 <= online_s4;
			hdg_s5    <= hdg_s4;
			ofs_s5    <= offset_enable ? ofs_s4 : 8'd0;
			spd_s5    <= (spd_c_s4 > trfe_pkg::SPD_FINE_MAX) ? {1'b1, spd_div}
				: spd_c_s4[7:0];
			clb_s5    <= {clb_c_s4 > 9'(trfe_pkg::SMALL_MAX), clb_bits};
		end
	end

	assign altitude_word = alt_s5;
	assign type_code     = type_s5;
	assign online_flag   = online_s5;
	assign speed_word    = spd_s5;
	assign climb_word    = clb_s5;
	assign heading_code  = hdg_s5;
	assign offset_word   = ofs_s5;

endmodule

// ===== src/tracking_report_field_encoder.sv =====
// ----------------------------------------------------------------------------
// tracking_report_field_encoder
// Turns one own-position sample into the quantized fields of an air-tracking
// report.
//
// Input beats arrive on s_axis, one sample per beat; report beats leave on
// m_axis, one per sample, in order. The APB port sets the source address
// and enables the pressure-altitude offset field; write it only while no
// beat is in flight.
// Throughput is one beat per cycle while m_axis_tready stays high: five
// register stages, each with its own valid bit, carry the reciprocal
// multiplies and the remainder correction of the coordinate quotients.
// Reset empties the pipeline, clears the source address and enables the
// offset field.
// When m_axis_tready is low the stages keep filling until all five hold a
// beat; only then does s_axis_tready drop. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module tracking_report_field_encoder (
	input  logic                            clk,
	input  logic                            arst_n,
	// lat[30:0] lon[62:31] alt[78:63] palt[94:79] speed[108:95]
	// climb[124:109] heading[139:125] kind[144:140] track_off[145] stealth[146]
	input  logic [trfe_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// source_address[23:0] lat_code[47:24] lon_code[71:48] altitude_word[83:72]
	// type_code[86:84] online_flag[87] speed_word[95:88] climb_word[103:96]
	// heading_code[111:104] offset_word[119:112]
	output logic [trfe_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [trfe_pkg::PADDR_W-1:0]    paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	trfe_pkg::stage_ctl_t ctl;

	logic [23:0] own_address_q;
	logic        offset_enable_q;
	logic        cfg_write;

	logic [23:0] lat_code;
	logic [23:0] lon_code;
	logic [11:0] altitude_word;
	logic [2:0]  type_code;
	logic        online_flag;
	logic [7:0]  speed_word;
	logic [7:0]  climb_word;
	logic [7:0]  heading_code;
	logic [7:0]  offset_word;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q   <= '0;
			offset_enable_q <= 1'b1;
		end else if (cfg_write) begin
			case (paddr[2])
				trfe_pkg::REG_OWN_ADDRESS: begin
					own_address_q <= pwdata[23:0];
				end
				trfe_pkg::REG_OFFSET_ENABLE: begin
					offset_enable_q <= pwdata[0];
				end
				default: begin
					own_address_q <= own_address_q;
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			trfe_pkg::REG_OWN_ADDRESS:   prdata = {8'd0, own_address_q};
			trfe_pkg::REG_OFFSET_ENABLE: prdata = {31'd0, offset_enable_q};
			default:                     prdata = '0;
		endcase
	end

	trfe_flow u_flow (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.out_ready (m_axis_tready),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.ctl       (ctl)
	);

	trfe_coord u_coord (
		.clk          (clk),
		.ctl          (ctl),
		.latitude_e7  (s_axis_tdata[30:0]),
		.longitude_e7 (s_axis_tdata[62:31]),
		.lat_code     (lat_code),
		.lon_code     (lon_code)
	);

	trfe_motion u_motion (
		.clk                 (clk),
		.ctl                 (ctl),
		.offset_enable       (offset_enable_q),
		.altitude_m          (s_axis_tdata[78:63]),
		.pressure_altitude_m (s_axis_tdata[94:79]),
		.speed_knots_q4      (s_axis_tdata[108:95]),
		.climb_fpm           (s_axis_tdata[124:109]),
		.heading_deg_q6      (s_axis_tdata[139:125]),
		.craft_kind          (s_axis_tdata[144:140]),
		.track_off           (s_axis_tdata[145]),
		.stealth             (s_axis_tdata[146]),
		.altitude_word       (altitude_word),
		.type_code           (type_code),
		.online_flag         (online_flag),
		.speed_word          (speed_word),
		.climb_word          (climb_word),
		.heading_code        (heading_code),
		.offset_word         (offset_word)
	);

	assign m_axis_tdata = {offset_word, heading_code, climb_word, speed_word, online_flag,
		type_code, altitude_word, lon_code, lat_code, own_address_q};

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with an empty output stage");

	a_alt_scale_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && altitude_word[11] |-> altitude_word[10:0] >= 11'd512)
		else $error("scaled altitude code below coarse range");

	a_speed_scale_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && speed_word[7] |-> speed_word[6:0] >= 7'd26)
		else $error("scaled speed code below coarse range");

	a_offset_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !offset_enable_q |-> offset_word == 8'd0)
		else $error("offset field filled while disabled");

	a_address_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write && paddr[2] == trfe_pkg::REG_OWN_ADDRESS
		|=> own_address_q == $past(pwdata[23:0]))
		else $error("source address write lost");

endmodule
